FILE: src/lrmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrmb_pkg: laser runtime meter and blinker shared definitions
// Word types, register indexes and constants used by the channels and the top.
// ----------------------------------------------------------------------------
package lrmb_pkg;

   localparam int unsigned DataWidth  = 16;
   localparam int unsigned PhaseWidth = 4;

   localparam logic [DataWidth-1:0]  TickWrap       = 16'd60000;
   localparam logic [PhaseWidth-1:0] PhaseLast      = 4'd9;
   localparam logic [DataWidth-1:0]  SeedThrReset   = 16'd90;
   localparam logic [DataWidth-1:0]  IrThrReset     = 16'd50;
   localparam logic [DataWidth-1:0]  UvThrReset     = 16'd50;
   localparam logic [DataWidth-1:0]  IntervalReset  = 16'd3600;

   typedef enum logic [1:0] {
      CSR_SEED_THRESHOLD = 2'd0,
      CSR_IR_THRESHOLD   = 2'd1,
      CSR_UV_THRESHOLD   = 2'd2,
      CSR_ACCRUAL        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 started;
      logic [DataWidth-1:0] seed_power;
      logic [DataWidth-1:0] infrared_power;
      logic [DataWidth-1:0] ultraviolet_power;
   } req_word_type;

   typedef struct packed {
      logic led_level;
      logic seed_pulse;
      logic infrared_pulse;
      logic ultraviolet_pulse;
   } rsp_word_type;

endpackage
`default_nettype wire

FILE: src/lrmb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrmb channels: valid/ready word channels for tick items and results
// A word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lrmb_req_if;
   logic                  valid;
   logic                  ready;
   lrmb_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lrmb_rsp_if;
   logic                  valid;
   logic                  ready;
   lrmb_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/laser_runtime_meter_and_blinker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laser_runtime_meter_and_blinker_top: tick-driven LED blinker and runtime meter
// Path: an accepted tick word passes the input register, then the result register.
// Throughput: 1 word per cycle; both stages advance together when the result
// register is empty or being taken.
// Reset: synchronous, clears tick/phase/LED/run counters, loads register defaults.
// ----------------------------------------------------------------------------
module laser_runtime_meter_and_blinker_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lrmb_req_if.sink                           req_bus,
   lrmb_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [lrmb_pkg::DataWidth-1:0] csr_wdata
);

   localparam int unsigned W  = lrmb_pkg::DataWidth;
   localparam int unsigned PW = lrmb_pkg::PhaseWidth;

   logic [W-1:0] seed_thr_ff, ir_thr_ff, uv_thr_ff, interval_ff;

   logic                   in_valid_ff;
   lrmb_pkg::req_word_type in_ff;
   logic                   rsp_valid_ff;
   lrmb_pkg::rsp_word_type rsp_ff;

   logic [W-1:0]  tick_ff, tick_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic          led_ff, led_in;
   logic [W-1:0]  seed_run_ff, seed_run_in;
   logic [W-1:0]  ir_run_ff, ir_run_in;
   logic [W-1:0]  uv_run_ff, uv_run_in;
   logic          seed_pulse, ir_pulse, uv_pulse;

   logic          advance;
   logic [W-1:0]  tick_inc;
   logic [W-1:0]  seed_inc, ir_inc, uv_inc;
   logic          toggle;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_thr_ff <= lrmb_pkg::SeedThrReset;
         ir_thr_ff   <= lrmb_pkg::IrThrReset;
         uv_thr_ff   <= lrmb_pkg::UvThrReset;
         interval_ff <= lrmb_pkg::IntervalReset;
      end else if (csr_we) begin
         unique case (lrmb_pkg::csr_index_type'(csr_index))
            lrmb_pkg::CSR_SEED_THRESHOLD: seed_thr_ff <= csr_wdata;
            lrmb_pkg::CSR_IR_THRESHOLD:   ir_thr_ff   <= csr_wdata;
            lrmb_pkg::CSR_UV_THRESHOLD:   uv_thr_ff   <= csr_wdata;
            lrmb_pkg::CSR_ACCRUAL:        interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tick update
   always_comb begin
      tick_inc = tick_ff + W'(1);
      phase_in = (phase_ff == lrmb_pkg::PhaseLast) ? '0 : phase_ff + PW'(1);
      toggle   = in_ff.started ? (phase_in == '0) : !tick_inc[0];
      led_in   = led_ff ^ toggle;
      tick_in  = (tick_inc >= lrmb_pkg::TickWrap) ? '0 : tick_inc;
   end

   // run counters
   always_comb begin
      seed_inc    = seed_run_ff + W'(1);
      ir_inc      = ir_run_ff + W'(1);
      uv_inc      = uv_run_ff + W'(1);
      seed_pulse  = 1'b0;
      ir_pulse    = 1'b0;
      uv_pulse    = 1'b0;
      seed_run_in = seed_run_ff;
      ir_run_in   = ir_run_ff;
      uv_run_in   = uv_run_ff;
      if (in_ff.seed_power > seed_thr_ff) begin
         seed_pulse  = seed_inc > interval_ff;
         seed_run_in = seed_pulse ? '0 : seed_inc;
      end
      if (in_ff.infrared_power > ir_thr_ff) begin
         ir_pulse  = ir_inc > interval_ff;
         ir_run_in = ir_pulse ? '0 : ir_inc;
      end
      if (in_ff.ultraviolet_power > uv_thr_ff) begin
         uv_pulse  = uv_inc > interval_ff;
         uv_run_in = uv_pulse ? '0 : uv_inc;
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         phase_ff     <= '0;
         led_ff       <= 1'b0;
         seed_run_ff  <= '0;
         ir_run_ff    <= '0;
         uv_run_ff    <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            tick_ff      <= tick_in;
            phase_ff     <= phase_in;
            led_ff       <= led_in;
            seed_run_ff  <= seed_run_in;
            ir_run_ff    <= ir_run_in;
            uv_run_ff    <= uv_run_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_ff <= req_bus.data;
      end
      if (advance) begin
         rsp_ff.led_level         <= led_in;
         rsp_ff.seed_pulse        <= seed_pulse;
         rsp_ff.infrared_pulse    <= ir_pulse;
         rsp_ff.ultraviolet_pulse <= uv_pulse;
      end
   end

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff < lrmb_pkg::TickWrap)
      else $error("tick counter out of range");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= lrmb_pkg::PhaseLast)
      else $error("blink phase out of range");

   a_led_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(led_ff))
      else $error("led changed without a word");

   a_led_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.led_level == led_ff)
      else $error("result led differs from led state");

   a_seed_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.seed_pulse |-> seed_run_ff == '0)
      else $error("seed pulse without counter clear");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result lost under stall");

endmodule
`default_nettype wire

FILE: dv/laser_runtime_meter_and_blinker_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laser_runtime_meter_and_blinker_top_tb: self-checking bench for the tick meter
// Sends tick words with random gaps and random result stalls, and predicts the
// LED level and the three runtime pulses for every accepted tick. Each result
// word is checked against the oldest prediction. The bench covers the register
// defaults, threshold and interval extremes, a long result stall and random
// register settings.
// ----------------------------------------------------------------------------
module laser_runtime_meter_and_blinker_top_tb;

   localparam int unsigned DataWidth    = lrmb_pkg::DataWidth;
   localparam int unsigned BlinkSlow    = 10;
   localparam int unsigned BlinkFast    = 2;
   localparam int unsigned MaxIdle      = 19;
   localparam int unsigned RandomItems  = 1300;
   localparam int unsigned RandomPhases = 6;
   localparam int unsigned HoldCycles   = 150;
   localparam int unsigned HoldItems    = 40;
   localparam int unsigned DrainCycles  = 4;
   localparam logic [DataWidth-1:0] IntervalMax = 16'd65534;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [1:0]           csr_index;
   logic [DataWidth-1:0] csr_wdata;

   lrmb_req_if req_bus ();
   lrmb_rsp_if rsp_bus ();

   laser_runtime_meter_and_blinker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [DataWidth-1:0] seed_thr, ir_thr, uv_thr, interval;
   logic [DataWidth-1:0] tick_count, seed_run, ir_run, uv_run;
   logic                 led_on;

   lrmb_pkg::rsp_word_type pending_words[$];
   int unsigned  mismatch_count = 0;
   bit           idle_on = 1'b0;
   int unsigned  hold_request = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #12000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic accrue(inout logic [DataWidth-1:0] run,
                                   input logic [DataWidth-1:0] power,
                                   input logic [DataWidth-1:0] limit);
      if (power > limit) begin
         run = run + 1'b1;
         if (run > interval) begin
            run = '0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic lrmb_pkg::rsp_word_type meter_tick(input lrmb_pkg::req_word_type w);
      lrmb_pkg::rsp_word_type r;
      int unsigned  period;
      tick_count = tick_count + 1'b1;
      period = w.started ? BlinkSlow : BlinkFast;
      if (tick_count % period == 0)
         led_on = ~led_on;
      r.seed_pulse        = accrue(seed_run, w.seed_power, seed_thr);
      r.infrared_pulse    = accrue(ir_run, w.infrared_power, ir_thr);
      r.ultraviolet_pulse = accrue(uv_run, w.ultraviolet_power, uv_thr);
      if (tick_count >= lrmb_pkg::TickWrap)
         tick_count = '0;
      r.led_level = led_on;
      return r;
   endfunction

   function automatic lrmb_pkg::req_word_type make_tick(input logic st,
                                              input logic [DataWidth-1:0] s,
                                              input logic [DataWidth-1:0] i,
                                              input logic [DataWidth-1:0] u);
      lrmb_pkg::req_word_type w;
      w.started           = st;
      w.seed_power        = s;
      w.infrared_power    = i;
      w.ultraviolet_power = u;
      return w;
   endfunction

   function automatic logic [DataWidth-1:0] pick_power(input logic [DataWidth-1:0] thr);
      logic [DataWidth-1:0] p;
      case ($urandom_range(0, 9))
         0: p = '0;
         1: p = '1;
         2, 3, 4: p = DataWidth'($urandom);
         default: p = DataWidth'(thr + $urandom_range(0, 4) - 2);
      endcase
      return p;
   endfunction

   function automatic logic [DataWidth-1:0] pick_threshold();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return DataWidth'($urandom);
      endcase
   endfunction

   function automatic logic [DataWidth-1:0] pick_interval();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return IntervalMax;
         default: return DataWidth'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic lrmb_pkg::req_word_type random_tick();
      return make_tick(1'($urandom_range(0, 1)), pick_power(seed_thr),
                       pick_power(ir_thr), pick_power(uv_thr));
   endfunction

   function automatic void check_bit(input string field, input logic want,
                                     input logic got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
      end
   endfunction

   task automatic send_tick(input lrmb_pkg::req_word_type w);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_words.push_back(meter_tick(w));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input lrmb_pkg::csr_index_type idx,
                            input logic [DataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [DataWidth-1:0] s, input logic [DataWidth-1:0] i,
                               input logic [DataWidth-1:0] u, input logic [DataWidth-1:0] a);
      write_reg(lrmb_pkg::CSR_SEED_THRESHOLD, s);
      write_reg(lrmb_pkg::CSR_IR_THRESHOLD, i);
      write_reg(lrmb_pkg::CSR_UV_THRESHOLD, u);
      write_reg(lrmb_pkg::CSR_ACCRUAL, a);
      csr_we   <= 1'b0;
      seed_thr = s;
      ir_thr   = i;
      uv_thr   = u;
      interval = a;
   endtask

   task automatic test_default_thresholds();
      idle_on = 1'b1;
      send_tick(make_tick(1'b0, lrmb_pkg::SeedThrReset, lrmb_pkg::IrThrReset,
                          lrmb_pkg::UvThrReset));
      send_tick(make_tick(1'b0, lrmb_pkg::SeedThrReset + 1'b1,
                          lrmb_pkg::IrThrReset + 1'b1, lrmb_pkg::UvThrReset + 1'b1));
      send_tick(make_tick(1'b1, '0, '0, '0));
      send_tick(make_tick(1'b1, '1, '1, '1));
      send_tick(make_tick(1'b0, lrmb_pkg::SeedThrReset - 1'b1,
                          lrmb_pkg::IrThrReset - 1'b1, lrmb_pkg::UvThrReset - 1'b1));
      send_tick(make_tick(1'b1, lrmb_pkg::SeedThrReset + 1'b1, lrmb_pkg::IrThrReset,
                          lrmb_pkg::UvThrReset + 1'b1));
      send_tick(make_tick(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA));
      send_tick(make_tick(1'b1, 16'h5555, 16'hAAAA, 16'h5555));
      drain();
   endtask

   task automatic test_small_interval();
      idle_on = 1'b0;
      program_regs('0, '1, 16'h8000, 16'd1);
      repeat (4) send_tick(make_tick(1'b0, 16'd1, '1, 16'h8001));
      send_tick(make_tick(1'b1, '0, '0, 16'h8000));
      send_tick(make_tick(1'b1, '1, '1, '1));
      send_tick(make_tick(1'b0, '1, '0, 16'h7FFF));
      send_tick(make_tick(1'b1, 16'd1, '1, '1));
      drain();
   endtask

   task automatic test_interval_extreme();
      idle_on = 1'b1;
      program_regs('1, '0, '0, IntervalMax);
      repeat (4) send_tick(random_tick());
      drain();
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      program_regs(pick_threshold(), pick_threshold(), pick_threshold(), 16'd3);
      hold_request = HoldCycles;
      repeat (HoldItems) send_tick(random_tick());
      drain();
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < RandomPhases; p++) begin
         idle_on = (p % 3 != 2);
         program_regs(pick_threshold(), pick_threshold(), pick_threshold(), pick_interval());
         repeat (RandomItems / RandomPhases) send_tick(random_tick());
         drain();
      end
   endtask

   initial begin : result_sink
      lrmb_pkg::rsp_word_type want;
      int unsigned  stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = hold_request != 0 ? hold_request :
                 (idle_on ? $urandom_range(0, MaxIdle) : 0);
         hold_request = 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (pending_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: result word %b with no tick pending", $time, rsp_bus.data);
         end else begin
            want = pending_words.pop_front();
            check_bit("led_level", want.led_level, rsp_bus.data.led_level);
            check_bit("seed_pulse", want.seed_pulse, rsp_bus.data.seed_pulse);
            check_bit("infrared_pulse", want.infrared_pulse,
                      rsp_bus.data.infrared_pulse);
            check_bit("ultraviolet_pulse", want.ultraviolet_pulse,
                      rsp_bus.data.ultraviolet_pulse);
         end
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= lrmb_pkg::CSR_SEED_THRESHOLD;
      csr_wdata     <= '0;
      seed_thr   = lrmb_pkg::SeedThrReset;
      ir_thr     = lrmb_pkg::IrThrReset;
      uv_thr     = lrmb_pkg::UvThrReset;
      interval   = lrmb_pkg::IntervalReset;
      tick_count = '0;
      seed_run   = '0;
      ir_run     = '0;
      uv_run     = '0;
      led_on     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_thresholds();
      test_small_interval();
      test_interval_extreme();
      test_backpressure();
      test_random_phases();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
